/* rtl/core/id3v2_frame_text_extractor_assert.svh */
// Assertion macros shared by the checker of the ID3v2 frame text extractor.
// Holds only macro definitions; it has no dependencies.
`ifndef ID3V2_FRAME_TEXT_EXTRACTOR_ASSERT_SVH
`define ID3V2_FRAME_TEXT_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ID3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("id3v2 checker: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define ID3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("id3v2 checker: property violated");

`endif

/* rtl/core/id3_pkg.sv */
// Package of the ID3v2 frame text extractor: result type, status codes and constants.
// Used by the front parser, the result queue, the output stage and the top level.
package id3_pkg;

    localparam logic [7:0]  MAGIC_0        = 8'h49;  // 'I'
    localparam logic [7:0]  MAGIC_1        = 8'h44;  // 'D'
    localparam logic [7:0]  MAGIC_2        = 8'h33;  // '3'
    localparam logic [7:0]  MAJOR_VERSION  = 8'h03;
    localparam logic [7:0]  PRINT_LOW      = 8'd32;
    localparam logic [7:0]  PRINT_HIGH     = 8'd126;
    localparam logic [29:0] HEADER_LEN     = 30'd10;
    localparam logic [28:0] POS_MAX        = 29'h1FFF_FFFF;
    localparam logic [31:0] TARGET_RESET   = 32'h5449_5432;  // "TIT2"
    localparam int          QUEUE_DEPTH_DEF = 4;

    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_FINISHED  = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_NOT_ID3   = 3'd3;
    localparam logic [2:0] ST_BAD_VER   = 3'd4;

    typedef struct packed {
        logic [2:0] status;
        logic       char_valid;
        logic [7:0] text_char;
    } t_result;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_status;

endpackage

/* rtl/core/id3v2_frame_text_extractor.sv */
// ID3v2.3 frame text extractor, top level.
// Bytes of a file enter on the slave stream, one word per byte: tdata carries the byte and
// tuser is set on the byte at file offset zero, which restarts the parse. The block checks
// the 10-byte tag header ("ID3", major version 3, syncsafe size), walks the frames, and for
// the first frame whose ID equals the configured ID sends each printable payload byte
// (32 to 126) out on the master stream. The master word also carries a status: frame
// finished on the frame's last byte, or frame not found, not ID3, unsupported version.
// Bytes that produce neither a character nor a status produce no output word.
// The frame ID is written on the configuration channel, which is ready whenever reset is
// released; write it only while no byte is in flight. First ID character sits in bits 31..24.
// Throughput is one byte per cycle while the queue is not full: the front parser updates
// its counters and compares combinationally. The edge that takes a byte writes its result
// into the queue; the output register loads the queue head when it is empty or being taken.
// When the receiver stalls, the output word holds and results pile up in the queue;
// s_axis_tready is low only in reset or with the queue full, and rises once a word leaves.
// Reset (synchronous, active low) returns the parser to the header, clears the queue and
// the output valid flag, and restores the frame ID "TIT2". No clearing pass is needed.
// After a final status the block stays silent until the next start-of-file byte.
// Depends on id3_pkg, id3_front, id3_queue and id3_back.
module id3v2_frame_text_extractor #(
    parameter int QUEUE_DEPTH = id3_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel: the target frame ID.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // Slave stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] start_of_file
    // Master stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] text_char
    output logic [3:0]  m_axis_tuser    // [0] char_valid, [3:1] status
);
    import id3_pkg::*;

    t_queue_status w_q_stat;
    t_result       w_push_data;
    t_result       w_head;
    t_result       w_out;
    logic          w_push;
    logic          w_pop;

    // The configuration register is a plain write; it stalls only during reset.
    assign o_cfg_ready = i_rst_n;

    id3_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_data_byte     (s_axis_tdata),
        .i_start_of_file (s_axis_tuser[0]),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_q_stat        (w_q_stat),
        .o_push          (w_push),
        .o_result        (w_push_data)
    );

    id3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    id3_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_out)
    );

    assign m_axis_tdata = w_out.text_char;
    assign m_axis_tuser = {w_out.status, w_out.char_valid};

endmodule

/* rtl/core/id3_front.sv */
// Front parser: accepts file bytes, walks the ID3v2.3 header and frames, forms results.
// Depends on id3_pkg.
module id3_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_start_of_file,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_data,
    input  id3_pkg::t_queue_status i_q_stat,
    output logic                 o_push,
    output id3_pkg::t_result     o_result
);
    import id3_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_FRAME_HDR,
        PH_PAYLOAD,
        PH_DONE
    } t_phase;

    t_phase      r_phase,  n_phase,  w_phase;
    logic [28:0] r_pos,    n_pos,    w_pos;
    logic [27:0] r_tag,    n_tag,    w_tag;
    logic [31:0] r_fid,    n_fid,    w_fid;
    logic [31:0] r_fbl,    n_fbl,    w_fbl;
    logic [3:0]  r_fc,     n_fc,     w_fc;
    logic        r_fm,     n_fm,     w_fm;
    logic [31:0] r_target;

    logic [29:0] w_pos_inc;
    logic [27:0] w_hdr_tag;
    logic [31:0] w_fid_new;
    logic [31:0] w_fbl_dec;
    logic        w_end_hdr;
    logic        w_end_frm;
    logic        w_accept;
    logic [2:0]  w_status;
    logic        w_char_valid;
    logic [7:0]  w_char;

    // A set start flag restarts the parse before this byte is looked at.
    always_comb begin
        if (i_start_of_file) begin
            w_phase = PH_HEADER;
            w_pos   = '0;
            w_tag   = '0;
            w_fid   = '0;
            w_fbl   = '0;
            w_fc    = '0;
            w_fm    = 1'b0;
        end else begin
            w_phase = r_phase;
            w_pos   = r_pos;
            w_tag   = r_tag;
            w_fid   = r_fid;
            w_fbl   = r_fbl;
            w_fc    = r_fc;
            w_fm    = r_fm;
        end
    end

    assign w_pos_inc = {1'b0, w_pos} + 30'd1;
    assign w_hdr_tag = {w_tag[20:0], i_data_byte[6:0]};
    assign w_fid_new = {w_fid[23:0], i_data_byte};
    assign w_fbl_dec = (w_fbl != 32'd0) ? (w_fbl - 32'd1) : w_fbl;
    // The tag ends once the next offset reaches tag_size plus the header length.
    assign w_end_hdr = (w_pos_inc >= ({2'b00, w_hdr_tag} + HEADER_LEN));
    assign w_end_frm = (w_pos_inc >= ({2'b00, w_tag} + HEADER_LEN));

    always_comb begin
        n_phase      = w_phase;
        n_tag        = w_tag;
        n_fid        = w_fid;
        n_fbl        = w_fbl;
        n_fc         = w_fc;
        n_fm         = w_fm;
        w_status     = ST_BUSY;
        w_char_valid = 1'b0;
        w_char       = 8'd0;
        n_pos        = (w_pos != POS_MAX) ? (w_pos + 29'd1) : w_pos;

        case (w_phase)
            PH_HEADER: begin
                if (w_pos == 29'd0 && i_data_byte != MAGIC_0) begin
                    w_status = ST_NOT_ID3;
                    n_phase  = PH_DONE;
                end else if (w_pos == 29'd1 && i_data_byte != MAGIC_1) begin
                    w_status = ST_NOT_ID3;
                    n_phase  = PH_DONE;
                end else if (w_pos == 29'd2 && i_data_byte != MAGIC_2) begin
                    w_status = ST_NOT_ID3;
                    n_phase  = PH_DONE;
                end else if (w_pos == 29'd3 && i_data_byte != MAJOR_VERSION) begin
                    w_status = ST_BAD_VER;
                    n_phase  = PH_DONE;
                end else if (w_pos >= 29'd6 && w_pos <= 29'd9) begin
                    n_tag = w_hdr_tag;
                    if (w_pos == 29'd9) begin
                        n_fc = '0;
                        if (w_end_hdr) begin
                            w_status = ST_NOT_FOUND;
                            n_phase  = PH_DONE;
                        end else begin
                            n_phase  = PH_FRAME_HDR;
                        end
                    end
                end
            end
            PH_FRAME_HDR: begin
                if (w_fc < 4'd4) begin
                    n_fid = w_fid_new;
                    if (w_fc == 4'd3) begin
                        n_fm = (w_fid_new == r_target);
                    end
                end else if (w_fc < 4'd8) begin
                    n_fbl = {w_fbl[23:0], i_data_byte};
                end
                if (w_fc >= 4'd9) begin
                    if (w_fbl != 32'd0) begin
                        n_phase = PH_PAYLOAD;
                        n_fc    = '0;
                    end else if (w_fm) begin
                        w_status = ST_FINISHED;
                        n_phase  = PH_DONE;
                    end else begin
                        n_fc = '0;
                        if (w_end_frm) begin
                            w_status = ST_NOT_FOUND;
                            n_phase  = PH_DONE;
                        end else begin
                            n_phase  = PH_FRAME_HDR;
                        end
                    end
                end else begin
                    n_fc = w_fc + 4'd1;
                end
            end
            PH_PAYLOAD: begin
                n_fbl = w_fbl_dec;
                if (w_fm && i_data_byte >= PRINT_LOW && i_data_byte <= PRINT_HIGH) begin
                    w_char_valid = 1'b1;
                    w_char       = i_data_byte;
                end
                if (w_fbl_dec == 32'd0) begin
                    if (w_fm) begin
                        w_status = ST_FINISHED;
                        n_phase  = PH_DONE;
                    end else begin
                        n_fc = '0;
                        if (w_end_frm) begin
                            w_status = ST_NOT_FOUND;
                            n_phase  = PH_DONE;
                        end else begin
                            n_phase  = PH_FRAME_HDR;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // No byte is taken while reset is held.
    assign o_ready  = i_rst_n && !i_q_stat.full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && (w_char_valid || (w_status != ST_BUSY));
    assign o_result = '{status: w_status, char_valid: w_char_valid, text_char: w_char};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_tag    <= '0;
            r_fid    <= '0;
            r_fbl    <= '0;
            r_fc     <= '0;
            r_fm     <= 1'b0;
            r_target <= TARGET_RESET;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
            if (w_accept) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_tag   <= n_tag;
                r_fid   <= n_fid;
                r_fbl   <= n_fbl;
                r_fc    <= n_fc;
                r_fm    <= n_fm;
            end
        end
    end

endmodule

/* rtl/core/id3_queue.sv */
// Short result queue between the front parser and the output stage.
// Depends on id3_pkg; DEPTH must be at least 2.
module id3_queue #(
    parameter int DEPTH = id3_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  id3_pkg::t_result       i_data,
    input  logic                   i_pop,
    output id3_pkg::t_result       o_head,
    output id3_pkg::t_queue_status o_stat
);
    import id3_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result       r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.not_empty = (r_count != '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && o_stat.not_empty;
    assign o_head = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : (r_wr_ptr + AW'(1));
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : (r_rd_ptr + AW'(1));
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* rtl/core/id3_back.sv */
// Output stage: moves queued results into the registered master-side word.
// Depends on id3_pkg.
module id3_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  id3_pkg::t_queue_status i_q_stat,
    input  id3_pkg::t_result       i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output id3_pkg::t_result       o_result
);
    import id3_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_pop    = i_q_stat.not_empty && (!r_valid || i_ready);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_head;
        end
    end

endmodule

/* rtl/core/id3_checker.sv */
// Port-level checker of the ID3v2 frame text extractor, bound to the top level.
// Depends on id3_pkg and id3v2_frame_text_extractor_assert.svh.
`include "id3v2_frame_text_extractor_assert.svh"

module id3_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [3:0] m_axis_tuser
);
    import id3_pkg::*;

    // A stalled output word holds until it is taken.
    `ID3_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // Every word carries a character or a final status.
    `ID3_ASSERT_IMPL(a_out_useful, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser[0] || (m_axis_tuser[3:1] != ST_BUSY))

    // A word without a character has a zero character field.
    `ID3_ASSERT_IMPL(a_char_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'd0)

    // A character is always printable.
    `ID3_ASSERT_IMPL(a_char_print, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata >= PRINT_LOW) && (m_axis_tdata <= PRINT_HIGH))

endmodule

bind id3v2_frame_text_extractor id3_checker u_checker (.*);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the ID3v2.3 frame text extractor: streams tags, broken headers
// and noise bytes through the slave stream and checks every master word against a predictor.
// Depends on id3_pkg and the id3v2_frame_text_extractor top level.
`timescale 1ns / 100ps

module tb_top;
    import id3_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int BYTES_PER_SET = 340;

    // Directed opening tag, sent without start of file: bit 7 set on every size byte,
    // a matching frame whose payload straddles both printable limits and ends unprintable.
    localparam logic [24*8-1:0] INTRO_TAG = {
        8'h49, 8'h44, 8'h33, 8'h03, 8'hFF, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h8E,
        8'h54, 8'h49, 8'h54, 8'h32, 8'h00, 8'h00, 8'h00, 8'h04, 8'hFF, 8'h00,
        8'h1F, 8'h20, 8'h7E, 8'h7F};

    typedef enum logic [1:0] {SEEK_HEADER, SEEK_FRAME_HDR, IN_PAYLOAD, PARSE_OVER} parse_phase_e;

    typedef struct {
        logic [7:0] data;
        logic       sof;
    } file_byte_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [31:0] i_cfg_data = 32'd0;
    logic        o_cfg_ready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [0:0]  s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [3:0]  m_axis_tuser;

    id3v2_frame_text_extractor uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state, a private copy of the parser.
    logic [31:0]  want_id = TARGET_RESET;
    logic [28:0]  byte_pos = '0;
    parse_phase_e phase = SEEK_HEADER;
    logic [27:0]  tag_len = '0;
    logic [31:0]  id_shift = '0;
    logic [31:0]  bytes_left = '0;
    logic [3:0]   hdr_cnt = '0;
    logic         id_hit = 1'b0;

    file_byte_t pending_q[$];
    t_result    results_due[$];

    logic [31:0] gen_target = TARGET_RESET;
    bit          calm_set = 1'b0;
    int drv_gap = 0;
    int rcv_gap = 0;
    int bytes_queued = 0;
    int bytes_taken = 0;
    int streams_built = 0;
    int target_writes = 0;
    int results_checked = 0;
    int mismatches = 0;
    int chars_seen = 0;
    int cycle_count = 0;
    int status_count [8];
    file_byte_t nxt;
    t_result    exp_res;

    function automatic void restart_parse();
        byte_pos   = '0;
        phase      = SEEK_HEADER;
        tag_len    = '0;
        id_shift   = '0;
        bytes_left = '0;
        hdr_cnt    = '0;
        id_hit     = 1'b0;
    endfunction

    function automatic logic [2:0] end_parse(input logic [2:0] code);
        phase = PARSE_OVER;
        return code;
    endfunction

    // The byte at offset p closes the header or a frame that is not the wanted one.
    function automatic logic [2:0] close_frame(input logic [28:0] p);
        hdr_cnt = '0;
        if ({3'd0, p} + 32'd1 >= {4'd0, tag_len} + {2'd0, HEADER_LEN})
            return end_parse(ST_NOT_FOUND);
        phase = SEEK_FRAME_HDR;
        return ST_BUSY;
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input logic sof);
        t_result     res;
        logic [28:0] p;
        res = '0;
        if (sof)
            restart_parse();
        p = byte_pos;
        case (phase)
            SEEK_HEADER: begin
                if (p == 29'd0 && b != MAGIC_0)
                    res.status = end_parse(ST_NOT_ID3);
                else if (p == 29'd1 && b != MAGIC_1)
                    res.status = end_parse(ST_NOT_ID3);
                else if (p == 29'd2 && b != MAGIC_2)
                    res.status = end_parse(ST_NOT_ID3);
                else if (p == 29'd3 && b != MAJOR_VERSION)
                    res.status = end_parse(ST_BAD_VER);
                else if (p >= 29'd6 && p <= 29'd9) begin
                    tag_len = {tag_len[20:0], b[6:0]};
                    if (p == 29'd9)
                        res.status = close_frame(p);
                end
            end
            SEEK_FRAME_HDR: begin
                if (hdr_cnt < 4'd4) begin
                    id_shift = {id_shift[23:0], b};
                    if (hdr_cnt == 4'd3)
                        id_hit = (id_shift == want_id);
                end else if (hdr_cnt < 4'd8) begin
                    bytes_left = {bytes_left[23:0], b};
                end
                if (hdr_cnt >= 4'd9) begin
                    if (bytes_left != 32'd0) begin
                        phase   = IN_PAYLOAD;
                        hdr_cnt = '0;
                    end else if (id_hit) begin
                        res.status = end_parse(ST_FINISHED);
                    end else begin
                        res.status = close_frame(p);
                    end
                end else begin
                    hdr_cnt = hdr_cnt + 4'd1;
                end
            end
            IN_PAYLOAD: begin
                if (bytes_left != 32'd0)
                    bytes_left = bytes_left - 32'd1;
                if (id_hit && b >= PRINT_LOW && b <= PRINT_HIGH) begin
                    res.char_valid = 1'b1;
                    res.text_char  = b;
                end
                if (bytes_left == 32'd0) begin
                    if (id_hit)
                        res.status = end_parse(ST_FINISHED);
                    else
                        res.status = close_frame(p);
                end
            end
            default: ;
        endcase
        if (byte_pos != POS_MAX)
            byte_pos = byte_pos + 29'd1;
        if (res.char_valid || res.status != ST_BUSY)
            results_due.push_back(res);
    endfunction

    // Mostly no gap, sometimes a short one, now and then a long one; never a gap in a calm set.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_set || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch on word %0d: %s is %0d, expected %0d",
                 results_checked, what, got, want);
    endtask

    // Slave side: offers the pending bytes in order and runs the predictor on each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_byte(s_axis_tdata, s_axis_tuser[0]);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    nxt = pending_q.pop_front();
                    s_axis_tdata  <= nxt.data;
                    s_axis_tuser  <= nxt.sof;
                    s_axis_tvalid <= 1'b1;
                    drv_gap = pick_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Master side: random stalls, each word compared with the oldest predicted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected word, status", int'(m_axis_tuser[3:1]), 0);
                end else begin
                    exp_res = results_due.pop_front();
                    if (m_axis_tdata !== exp_res.text_char)
                        report_mismatch("text_char", int'(m_axis_tdata),
                                        int'(exp_res.text_char));
                    if (m_axis_tuser[0] !== exp_res.char_valid)
                        report_mismatch("char_valid", int'(m_axis_tuser[0]),
                                        int'(exp_res.char_valid));
                    if (m_axis_tuser[3:1] !== exp_res.status)
                        report_mismatch("status", int'(m_axis_tuser[3:1]),
                                        int'(exp_res.status));
                end
                if (m_axis_tuser[0] === 1'b1)
                    chars_seen++;
                status_count[m_axis_tuser[3:1]]++;
                results_checked++;
            end
            if (rcv_gap > 0) begin
                rcv_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                rcv_gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, results_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic sof);
        pending_q.push_back('{b, sof});
        bytes_queued++;
    endtask

    task automatic push_noise(input int n);
        repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    function automatic logic [7:0] id_char();
        if ($urandom_range(0, 3) == 0)
            return 8'h30 + 8'($urandom_range(0, 9));
        return 8'h41 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] magic_at(input int k);
        return (k == 0) ? MAGIC_0 : (k == 1) ? MAGIC_1 : (k == 2) ? MAGIC_2 : MAJOR_VERSION;
    endfunction

    function automatic logic [7:0] wrong_byte(input logic [7:0] good);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == good)
            b = b ^ (8'd1 << $urandom_range(0, 7));
        return b;
    endfunction

    // A tag: header whose size may be off, up to four frames, sometimes padding, then a little audio.
    task automatic build_tag();
        logic [7:0]  body[$];
        logic [31:0] fid;
        logic [31:0] fsz;
        logic [27:0] tsize;
        int nfr, plen, adj;
        nfr = $urandom_range(0, 4);
        for (int k = 0; k < nfr; k++) begin
            if ($urandom_range(0, 2) == 0)
                fid = gen_target;
            else if ($urandom_range(0, 9) == 0)
                fid = $urandom;
            else
                fid = {id_char(), id_char(), id_char(), id_char()};
            plen = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 12);
            fsz = 32'(plen);
            // A frame that is not wanted may claim a huge size and swallow the rest.
            if (fid != gen_target && $urandom_range(0, 19) == 0)
                fsz = $urandom;
            for (int j = 3; j >= 0; j--)
                body.push_back(fid[j*8 +: 8]);
            for (int j = 3; j >= 0; j--)
                body.push_back(fsz[j*8 +: 8]);
            body.push_back(8'($urandom_range(0, 255)));
            body.push_back(8'($urandom_range(0, 255)));
            for (int j = 0; j < plen; j++)
                body.push_back(($urandom_range(0, 9) < 7) ? 8'($urandom_range(32, 126))
                                                          : 8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 2) * 10) body.push_back(8'h00);
        adj = $urandom_range(0, 9);
        if (adj < 6)
            adj = 0;
        else if (adj < 8)
            adj = -$urandom_range(1, 12);
        else
            adj = $urandom_range(1, 12);
        tsize = (body.size() + adj < 0) ? 28'd0 : 28'(body.size() + adj);
        if ($urandom_range(0, 24) == 0)
            tsize = '1;
        push_byte(MAGIC_0, 1'b1);
        push_byte(MAGIC_1, 1'b0);
        push_byte(MAGIC_2, 1'b0);
        push_byte(MAJOR_VERSION, 1'b0);
        push_noise(2);
        for (int j = 3; j >= 0; j--)
            push_byte({($urandom_range(0, 3) == 0), tsize[j*7 +: 7]}, 1'b0);
        foreach (body[j])
            push_byte(body[j], 1'b0);
        push_noise($urandom_range(0, 4));
        streams_built++;
    endtask

    // Random mix: mostly good tags, then bad magic, bad version, cut headers and noise.
    task automatic fill_set(input int goal);
        int kind, k;
        while (bytes_queued < goal) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                build_tag();
            end else if (kind < 84) begin
                // Wrong byte at one of the magic offsets, or at the version offset.
                k = (kind < 78) ? $urandom_range(0, 2) : 3;
                for (int j = 0; j < k; j++)
                    push_byte(magic_at(j), j == 0);
                push_byte(wrong_byte(magic_at(k)), k == 0);
                push_noise($urandom_range(0, 3));
                streams_built++;
            end else if (kind < 92) begin
                k = $urandom_range(1, 9);
                for (int j = 0; j < k; j++)
                    push_byte((j < 4) ? magic_at(j) : 8'($urandom_range(0, 255)), j == 0);
                streams_built++;
            end else begin
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // Sender holds back until every predicted word has come, then lets the pipe drain.
    task automatic wait_quiet();
        while (pending_q.size() != 0 || bytes_taken != bytes_queued || results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do
            @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        want_id = v;
        i_cfg_valid <= 1'b0;
        target_writes++;
    endtask

    initial begin
        logic [31:0] set_ids [6];
        set_ids[0] = TARGET_RESET;
        set_ids[1] = 32'h0000_0000;
        set_ids[2] = 32'hFFFF_FFFF;
        set_ids[3] = 32'h5450_4531;
        set_ids[4] = {id_char(), id_char(), id_char(), id_char()};
        set_ids[5] = TARGET_RESET;
        foreach (status_count[k])
            status_count[k] = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: the first byte after reset comes without start of file.
        for (int k = 0; k < 24; k++)
            push_byte(INTRO_TAG[(23 - k) * 8 +: 8], 1'b0);
        push_byte(8'h58, 1'b1);
        streams_built += 2;

        for (int s = 0; s < 6; s++) begin
            if (s != 0) begin
                wait_quiet();
                write_target(set_ids[s]);
            end
            gen_target = set_ids[s];
            calm_set   = (s == 2);
            fill_set((s + 1) * BYTES_PER_SET);
        end
        wait_quiet();

        $display("Streamed %0d bytes in %0d files under %0d frame ID settings; %0d words checked.",
                 bytes_taken, streams_built, target_writes + 1, results_checked);
        $display("Characters %0d, finished %0d, not found %0d, not ID3 %0d, bad version %0d.",
                 chars_seen, status_count[ST_FINISHED], status_count[ST_NOT_FOUND],
                 status_count[ST_NOT_ID3], status_count[ST_BAD_VER]);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/id3_pkg.sv
rtl/core/id3_front.sv
rtl/core/id3_queue.sv
rtl/core/id3_back.sv
rtl/core/id3v2_frame_text_extractor.sv
rtl/core/id3_checker.sv
tb/sv/tb_top.sv
